[design/awis_pkg.sv]
// shared types, constants and helpers for the area-weighted image scaler
package awis_pkg;

  localparam int unsigned MAX_SRC_WIDTH  = 256;
  localparam int unsigned MAX_SRC_HEIGHT = 256;
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned OUT_DIM_MAX    = 256;

  localparam int unsigned DIM_BITS  = 9;
  localparam int unsigned DIV_BITS  = 17;
  localparam int unsigned NUM_BITS  = 33;
  localparam int unsigned POS_BITS  = 17;
  localparam int unsigned STEP_BITS = 6;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_DIVISOR    = 3'd4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    DS_SY0,
    DS_SY1,
    DS_SX0,
    DS_SX1,
    DS_FIN
  } div_sel_t;

  typedef struct packed {
    logic     mem_we;
    logic     latch;
    logic     setup;
    logic     div_load;
    logic     div_step;
    logic     div_store;
    logic     init;
    logic     rd;
    logic     mul;
    logic     prod;
    logic     acc;
    logic     out_load;
    div_sel_t div_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic div_last;
    logic last_col;
    logic last_row;
  } dp_status_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] hi);
    logic [DIM_BITS-1:0] r;
    if (v == '0) r = DIM_BITS'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

[design/awis_datapath.sv]
// datapath: config registers, source store, shared divider, weighting and accumulator
module awis_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [16:0]            cfg_data,
  input  logic [7:0]             in_src_x,
  input  logic [7:0]             in_src_y,
  input  logic [15:0]            in_sample_in,
  input  logic [7:0]             in_out_row,
  input  logic [7:0]             in_out_col,
  input  awis_pkg::dp_cmd_t      cmd,
  output awis_pkg::dp_status_t   status,
  output logic [7:0]             out_res_row,
  output logic [7:0]             out_res_col,
  output logic [15:0]            out_res_sample
);

  localparam int unsigned DB = awis_pkg::DIM_BITS;
  localparam int unsigned VB = awis_pkg::DIV_BITS;
  localparam int unsigned NB = awis_pkg::NUM_BITS;
  localparam int unsigned PB = awis_pkg::POS_BITS;
  localparam int unsigned SB = awis_pkg::SAMPLE_BITS;

  logic [DB-1:0] sw_r, sh_r, ow_r, oh_r;
  logic [VB-1:0] dv_r;
  logic [DB-1:0] sw, sh, ow, oh;
  logic [VB-1:0] dv;

  logic [15:0] mem [awis_pkg::MAX_SRC_WIDTH*awis_pkg::MAX_SRC_HEIGHT];
  logic [15:0] rd_r;

  logic [7:0]    row_r, col_r;
  logic [PB-1:0] y0_r, y1_r, x0_r, x1_r;
  logic [DB-1:0] sy0_r, sy1_r, sx0_r, sx1_r, sy_r, sx_r;
  logic [PB-1:0] cy_r, cx_r, cx0_r;
  logic [DB-1:0] wx_r, wy_r;
  logic [PB-1:0] w_r;
  logic [NB-1:0] prod_r, acc_r;
  logic [15:0]   res_r;

  logic [NB-1:0]      num_r, q_r;
  logic [VB-1:0]      den_r, rem_r;
  logic [awis_pkg::STEP_BITS-1:0] cnt_r;

  logic [NB-1:0] num_sel;
  logic [VB-1:0] den_sel;
  logic [VB:0]   rem_sh;
  logic          q_bit;
  logic [VB:0]   rem_diff;
  logic [PB:0]   ylo, yhi, xlo, xhi, cy_end, cx_end;
  logic [DB-1:0] clip_y, clip_x;

  assign sw = awis_pkg::clamp_dim(sw_r, DB'(awis_pkg::MAX_SRC_WIDTH));
  assign sh = awis_pkg::clamp_dim(sh_r, DB'(awis_pkg::MAX_SRC_HEIGHT));
  assign ow = awis_pkg::clamp_dim(ow_r, DB'(awis_pkg::OUT_DIM_MAX));
  assign oh = awis_pkg::clamp_dim(oh_r, DB'(awis_pkg::OUT_DIM_MAX));
  assign dv = (dv_r == '0) ? VB'(1) : dv_r;

  assign status.in_range = ({1'b0, in_out_row} < oh) && ({1'b0, in_out_col} < ow);
  assign status.div_last = (cnt_r == awis_pkg::STEP_BITS'(NB - 1));
  assign status.last_col = ((sx_r + DB'(1)) == sx1_r);
  assign status.last_row = ((sy_r + DB'(1)) == sy1_r);

  always_comb begin
    case (cmd.div_sel)
      awis_pkg::DS_SY0: begin
        num_sel = NB'(y0_r);
        den_sel = VB'(oh);
      end
      awis_pkg::DS_SY1: begin
        num_sel = NB'({1'b0, y1_r} + (PB+1)'(oh) - (PB+1)'(1));
        den_sel = VB'(oh);
      end
      awis_pkg::DS_SX0: begin
        num_sel = NB'(x0_r);
        den_sel = VB'(ow);
      end
      awis_pkg::DS_SX1: begin
        num_sel = NB'({1'b0, x1_r} + (PB+1)'(ow) - (PB+1)'(1));
        den_sel = VB'(ow);
      end
      default: begin
        num_sel = acc_r + NB'(dv >> 1);
        den_sel = dv;
      end
    endcase
  end

  assign rem_sh   = {rem_r, num_r[NB-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign q_bit    = (rem_sh >= {1'b0, den_r});

  assign clip_y = (q_r > NB'(sh)) ? sh : q_r[DB-1:0];
  assign clip_x = (q_r > NB'(sw)) ? sw : q_r[DB-1:0];

  assign cy_end = {1'b0, cy_r} + (PB+1)'(oh);
  assign cx_end = {1'b0, cx_r} + (PB+1)'(ow);
  assign ylo = ({1'b0, y0_r} > {1'b0, cy_r}) ? {1'b0, y0_r} : {1'b0, cy_r};
  assign yhi = ({1'b0, y1_r} < cy_end) ? {1'b0, y1_r} : cy_end;
  assign xlo = ({1'b0, x0_r} > {1'b0, cx_r}) ? {1'b0, x0_r} : {1'b0, cx_r};
  assign xhi = ({1'b0, x1_r} < cx_end) ? {1'b0, x1_r} : cx_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= DB'(1);
      sh_r <= DB'(1);
      ow_r <= DB'(1);
      oh_r <= DB'(1);
      dv_r <= VB'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        awis_pkg::REG_SRC_WIDTH:  sw_r <= cfg_data[DB-1:0];
        awis_pkg::REG_SRC_HEIGHT: sh_r <= cfg_data[DB-1:0];
        awis_pkg::REG_OUT_WIDTH:  ow_r <= cfg_data[DB-1:0];
        awis_pkg::REG_OUT_HEIGHT: oh_r <= cfg_data[DB-1:0];
        awis_pkg::REG_DIVISOR:    dv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // source store, row-major
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[{in_src_y, in_src_x}] <= in_sample_in[SB-1:0];
    end
    if (cmd.rd) begin
      rd_r <= mem[{sy_r[7:0], sx_r[7:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      row_r <= in_out_row;
      col_r <= in_out_col;
      acc_r <= '0;
    end
    if (cmd.setup) begin
      y0_r <= PB'(row_r * sh);
      y1_r <= PB'(({1'b0, row_r} + DB'(1)) * sh);
      x0_r <= PB'(col_r * sw);
      x1_r <= PB'(({1'b0, col_r} + DB'(1)) * sw);
    end
    if (cmd.div_load) begin
      num_r <= num_sel;
      den_r <= den_sel;
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      num_r <= {num_r[NB-2:0], 1'b0};
      rem_r <= q_bit ? rem_diff[VB-1:0] : rem_sh[VB-1:0];
      q_r   <= {q_r[NB-2:0], q_bit};
      cnt_r <= cnt_r + awis_pkg::STEP_BITS'(1);
    end
    if (cmd.div_store) begin
      case (cmd.div_sel)
        awis_pkg::DS_SY0: sy0_r <= q_r[DB-1:0];
        awis_pkg::DS_SY1: sy1_r <= clip_y;
        awis_pkg::DS_SX0: sx0_r <= q_r[DB-1:0];
        awis_pkg::DS_SX1: sx1_r <= clip_x;
        default:          res_r <= q_r[15:0];
      endcase
    end
    if (cmd.init) begin
      sy_r  <= sy0_r;
      sx_r  <= sx0_r;
      cy_r  <= PB'(sy0_r * oh);
      cx_r  <= PB'(sx0_r * ow);
      cx0_r <= PB'(sx0_r * ow);
    end
    if (cmd.rd) begin
      wy_r <= DB'(yhi - ylo);
      wx_r <= DB'(xhi - xlo);
    end
    if (cmd.mul) begin
      w_r <= PB'(wx_r * wy_r);
    end
    if (cmd.prod) begin
      prod_r <= NB'(rd_r * w_r);
    end
    if (cmd.acc) begin
      acc_r <= acc_r + prod_r;
      if (status.last_col) begin
        sx_r <= sx0_r;
        cx_r <= cx0_r;
        sy_r <= sy_r + DB'(1);
        cy_r <= PB'(cy_end);
      end else begin
        sx_r <= sx_r + DB'(1);
        cx_r <= PB'(cx_end);
      end
    end
    if (cmd.out_load) begin
      out_res_row    <= row_r;
      out_res_col    <= col_r;
      out_res_sample <= res_r;
    end
  end

endmodule

[design/awis_ctrl.sv]
// controller: command sequencing, divider scheduling and output word handshake
module awis_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  awis_pkg::dp_status_t status,
  output awis_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_DLOAD,
    S_DRUN,
    S_DSTORE,
    S_INIT,
    S_RD,
    S_MUL,
    S_PROD,
    S_ACC,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  awis_pkg::div_sel_t sel_r, sel_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.div_sel   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == awis_pkg::CMD_LOAD) begin
            cmd.mem_we = 1'b1;
          end else if (status.in_range) begin
            cmd.latch = 1'b1;
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        sel_nxt   = awis_pkg::DS_SY0;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DRUN;
      end
      S_DRUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_DSTORE;
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        case (sel_r)
          awis_pkg::DS_SY0: begin
            sel_nxt   = awis_pkg::DS_SY1;
            state_nxt = S_DLOAD;
          end
          awis_pkg::DS_SY1: begin
            sel_nxt   = awis_pkg::DS_SX0;
            state_nxt = S_DLOAD;
          end
          awis_pkg::DS_SX0: begin
            sel_nxt   = awis_pkg::DS_SX1;
            state_nxt = S_DLOAD;
          end
          awis_pkg::DS_SX1: state_nxt = S_INIT;
          default:          state_nxt = S_OUT;
        endcase
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (status.last_col && status.last_row) begin
          sel_nxt   = awis_pkg::DS_FIN;
          state_nxt = S_DLOAD;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= awis_pkg::DS_SY0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/area_weighted_image_scaler.sv]
// top level of the area-weighted image scaler
// a load word leaves the scaler idle, so a new word can be taken in the next cycle
// a compute word runs five divisions on the shared divider and a read, multiply, product and
// accumulate walk over the cells, the overlapped source samples; the next word is taken once
// the result is loaded to the output, which waits while a stalled result holds the output
// synchronous active-low reset clears control and config; the source store is not cleared
module area_weighted_image_scaler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_src_x,
  input  logic [7:0]  in_src_y,
  input  logic [15:0] in_sample_in,
  input  logic [7:0]  in_out_row,
  input  logic [7:0]  in_out_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_res_row,
  output logic [7:0]  out_res_col,
  output logic [15:0] out_res_sample
);

  awis_pkg::dp_cmd_t    cmd;
  awis_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  awis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  awis_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_src_x       (in_src_x),
    .in_src_y       (in_src_y),
    .in_sample_in   (in_sample_in),
    .in_out_row     (in_out_row),
    .in_out_col     (in_out_col),
    .cmd            (cmd),
    .status         (status),
    .out_res_row    (out_res_row),
    .out_res_col    (out_res_col),
    .out_res_sample (out_res_sample)
  );

endmodule
